FILE: src/modular_exponentiation_top_macros.svh
// Assertion macros shared by the modular exponentiation checker.
`ifndef MODULAR_EXPONENTIATION_TOP_MACROS_SVH
`define MODULAR_EXPONENTIATION_TOP_MACROS_SVH

// Concurrent property checked on every rising edge outside reset
`define MEXP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Next-cycle implication: cons must follow ante
`define MEXP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/mexp_pkg.sv
// Shared types and constants for the modular exponentiation block.
package mexp_pkg;

	// Prime modulus and the fixed Fermat exponent for inversion
	localparam logic [29:0] PRIME      = 30'd1000000007;
	localparam logic [29:0] FERMAT_EXP = 30'd1000000005;

	// Barrett constant floor(2^60 / PRIME)
	localparam logic [30:0] BARRETT_M  = 31'd1152921496;

	// Base reduction: two base bits folded in per cycle over a 64-bit window
	localparam int RED_STEPS = 32;
	localparam int RED_CNT_W = $clog2(RED_STEPS);

	// Modular multiply pipeline latency
	localparam int MUL_LAT = 4;

	typedef logic [29:0] residue_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic red_step;
		logic update;
	} mexp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic e_zero;
		logic e_last;
	} mexp_sts_t;

endpackage

FILE: src/mexp_mulmod.sv
// Four-stage Barrett modular multiplier for residues modulo the prime.
module mexp_mulmod
	import mexp_pkg::*;
(
	input  logic     clk,
	input  residue_t a,
	input  residue_t b,
	output residue_t y
);

	localparam logic [31:0] P1 = 32'(PRIME);
	localparam logic [31:0] P2 = 32'(PRIME) << 1;

	logic [59:0] x_s1;
	logic [31:0] xl_s2;
	logic [30:0] q_s2;
	logic [31:0] t_s3;
	residue_t    y_s4;

	logic [61:0] qm;
	logic [31:0] qp;

	// Stage 1: full product, below 2^60
	always_ff @(posedge clk) begin
		x_s1 <= 60'(a) * 60'(b);
	end

	// Stage 2: quotient estimate from the top 31 product bits
	assign qm = 62'(x_s1[59:29]) * 62'(BARRETT_M);

	always_ff @(posedge clk) begin
		q_s2  <= qm[61:31];
		xl_s2 <= x_s1[31:0];
	end

	// Stage 3: remainder estimate, below 3P so 32 bits hold it exactly
	assign qp = 32'(q_s2) * P1;

	always_ff @(posedge clk) begin
		t_s3 <= xl_s2 - qp;
	end

	// Stage 4: final correction into 0 .. P-1
	always_ff @(posedge clk) begin
		priority if (t_s3 >= P2) begin
			y_s4 <= residue_t'(t_s3 - P2);
		end else if (t_s3 >= P1) begin
			y_s4 <= residue_t'(t_s3 - P1);
		end else begin
			y_s4 <= residue_t'(t_s3);
		end
	end

	assign y = y_s4;

endmodule

FILE: src/mexp_dp.sv
// Datapath: base reduction, exponent shifter and the square/multiply units.
module mexp_dp
	import mexp_pkg::*;
#(
	parameter int EXPONENT_BITS = 63
) (
	input  logic        clk,
	input  mexp_cmd_t   cmd,
	input  logic        func,
	input  logic [62:0] base,
	input  logic [62:0] exponent,
	output mexp_sts_t   sts,
	output residue_t    result
);

	localparam int EW = (EXPONENT_BITS > 30) ? EXPONENT_BITS : 30;

	localparam logic [31:0] P1 = 32'(PRIME);
	localparam logic [31:0] P2 = 32'(PRIME) << 1;
	localparam logic [31:0] P3 = (32'(PRIME) << 1) + 32'(PRIME);

	logic [63:0]   bsh_q;
	logic [EW-1:0] e_q;
	residue_t      acc_q;
	residue_t      sq_q;

	logic [31:0] red_t;
	residue_t    red_next;
	residue_t    y_acc;
	residue_t    y_sq;

	// Base reduction step: fold in two bits, subtract up to 3P
	assign red_t = {sq_q, bsh_q[63:62]};

	always_comb begin
		priority if (red_t >= P3) begin
			red_next = residue_t'(red_t - P3);
		end else if (red_t >= P2) begin
			red_next = residue_t'(red_t - P2);
		end else if (red_t >= P1) begin
			red_next = residue_t'(red_t - P1);
		end else begin
			red_next = residue_t'(red_t);
		end
	end

	// Multiply by the running square, and square it, in parallel
	mexp_mulmod u_mul_acc (
		.clk (clk),
		.a   (acc_q),
		.b   (sq_q),
		.y   (y_acc)
	);

	mexp_mulmod u_mul_sq (
		.clk (clk),
		.a   (sq_q),
		.b   (sq_q),
		.y   (y_sq)
	);

	// Working registers
	always_ff @(posedge clk) begin
		priority if (cmd.load) begin
			bsh_q <= {1'b0, base};
			sq_q  <= '0;
			acc_q <= residue_t'(1);
			e_q   <= func ? EW'(FERMAT_EXP) : EW'(exponent[EXPONENT_BITS-1:0]);
		end else if (cmd.red_step) begin
			bsh_q <= {bsh_q[61:0], 2'b00};
			sq_q  <= red_next;
		end else if (cmd.update) begin
			if (e_q[0]) begin
				acc_q <= y_acc;
			end
			sq_q <= y_sq;
			e_q  <= e_q >> 1;
		end else begin
			// no command: hold
		end
	end

	// Status toward the controller
	assign sts.e_zero = (e_q == '0);
	assign sts.e_last = (e_q[EW-1:1] == '0);

	assign result = acc_q;

endmodule

FILE: src/mexp_ctrl.sv
// Controller: sequences reduction, the bit loop and the result strobe.
module mexp_ctrl
	import mexp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  mexp_sts_t sts,
	output mexp_cmd_t cmd,
	output logic      busy,
	output logic      done
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_RED  = 4'b0010,
		ST_MUL  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t               state_q;
	state_t               state_d;
	logic [RED_CNT_W-1:0] cnt_q;
	logic [RED_CNT_W-1:0] cnt_d;

	// Next state and commands
	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		cmd.load     = 1'b0;
		cmd.red_step = 1'b0;
		cmd.update   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					cnt_d    = '0;
					state_d  = ST_RED;
				end
			end
			ST_RED: begin
				cmd.red_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == RED_CNT_W'(RED_STEPS - 1)) begin
					cnt_d   = '0;
					state_d = sts.e_zero ? ST_DONE : ST_MUL;
				end
			end
			ST_MUL: begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == RED_CNT_W'(MUL_LAT)) begin
					cmd.update = 1'b1;
					cnt_d      = '0;
					if (sts.e_last) begin
						state_d = ST_DONE;
					end
				end
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State and counter registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);

endmodule

FILE: src/modular_exponentiation_top.sv
// Top level: modular exponentiation and inversion modulo 1000000007.
//
//   beat      handshake              payload
//   command   start while busy low   func, base, exponent
//   result    done (one cycle)       result
//
// A job first reduces the base, then takes one square/multiply step per
// exponent bit up to the highest set bit (n bits; n = 30 in inverse mode).
// done rises after the last bit step, or right after reduction when the
// exponent is zero; each step waits on the four-stage multiply pipeline.
// busy stays high from the accepting edge through the done cycle.
// arst_n clears the controller only; the receiver cannot stall a result.
module modular_exponentiation_top
	import mexp_pkg::*;
#(
	parameter int EXPONENT_BITS = 63
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        func,
	input  logic [62:0] base,
	input  logic [62:0] exponent,
	output logic        done,
	output logic [29:0] result
);

	mexp_cmd_t cmd;
	mexp_sts_t sts;

	mexp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	mexp_dp #(
		.EXPONENT_BITS (EXPONENT_BITS)
	) u_dp (
		.clk      (clk),
		.cmd      (cmd),
		.func     (func),
		.base     (base),
		.exponent (exponent),
		.sts      (sts),
		.result   (result)
	);

endmodule

FILE: src/mexp_checker.sv
// Port-level checker for the modular exponentiation top, with its bind.
`include "modular_exponentiation_top_macros.svh"

module mexp_checker
	import mexp_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [29:0] result
);

	// Result strobe only while a job is in flight
	`MEXP_ASSERT(a_done_busy, !done || busy, "done outside a job")

	// An accepted command beat starts a job
	`MEXP_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted start did not raise busy")

	// Result beats never run back to back
	`MEXP_ASSERT_NEXT(a_done_single, done, !done, "done held longer than one cycle")

	// Result is a reduced residue
	`MEXP_ASSERT(a_result_range, !done || (result < PRIME), "result not reduced")

	// A job ends only through its result beat
	`MEXP_ASSERT(a_busy_end, !$fell(busy) || $past(done), "busy dropped without a result")

endmodule

bind modular_exponentiation_top mexp_checker u_mexp_checker (.*);

FILE: test/tb_top.sv
// Testbench for the modular exponentiation block: directed and random commands.
`timescale 1ns / 1ps

module tb_top;
	import mexp_pkg::*;

	localparam int          EXP_BITS   = 63;
	localparam logic [63:0] MODULUS    = 64'd1000000007;
	localparam logic [62:0] FERMAT_POW = 63'd1000000005;
	localparam logic [62:0] ALL_ONES   = {63{1'b1}};
	localparam int          TAIL_WAIT  = 400;
	localparam longint      CYCLE_CAP  = 1000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        func = 1'b0;
	logic [62:0] base = '0;
	logic [62:0] exponent = '0;
	logic        busy;
	logic        done;
	logic [29:0] result;

	residue_t expected_residues[$];
	int       pow_cmds = 0;
	int       inv_cmds = 0;
	int       checked = 0;
	int       mismatches = 0;
	longint   cycle_count = 0;

	modular_exponentiation_top #(
		.EXPONENT_BITS(EXP_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.base(base),
		.exponent(exponent),
		.done(done),
		.result(result)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_CAP) begin
			$display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
				cycle_count, expected_residues.size());
			$display("status: fail");
			$finish;
		end
	end

	// Product of two residues, reduced; both operands are below 2^30
	function automatic logic [63:0] mul_mod(input logic [63:0] a, input logic [63:0] b);
		return (a * b) % MODULUS;
	endfunction

	// Right-to-left square-and-multiply over the low nbits of e
	function automatic residue_t pow_mod(input logic [62:0] b, input logic [62:0] e,
			input int nbits);
		logic [63:0] acc;
		logic [63:0] sq;
		acc = 64'd1;
		sq = {1'b0, b} % MODULUS;
		for (int i = 0; i < nbits; i++) begin
			if (e[i])
				acc = mul_mod(acc, sq);
			sq = mul_mod(sq, sq);
		end
		return acc[29:0];
	endfunction

	// Inverse mode always scans the full Fermat exponent
	function automatic residue_t residue_of(input logic f, input logic [62:0] b,
			input logic [62:0] e);
		return f ? pow_mod(b, FERMAT_POW, 63) : pow_mod(b, e, EXP_BITS);
	endfunction

	function automatic logic [62:0] rand63();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[62:0];
	endfunction

	// Result check: done lasts one cycle, sampled mid-cycle
	always @(negedge clk) begin
		if (arst_n && done) begin
			if (expected_residues.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result beat, expected none, actual %0d", $time, result);
			end else begin
				checked++;
				if (result !== expected_residues[0]) begin
					mismatches++;
					$display("%0t: result mismatch, expected %0d, actual %0d", $time,
						expected_residues[0], result);
				end
				void'(expected_residues.pop_front());
			end
		end
	end

	// Send one command beat; start stays high until the caller pauses
	task automatic issue_cmd(input logic f, input logic [62:0] b, input logic [62:0] e);
		start <= 1'b1;
		func <= f;
		base <= b;
		exponent <= e;
		do
			@(negedge clk);
		while (busy);
		@(posedge clk);
		expected_residues.push_back(residue_of(f, b, e));
		if (f)
			inv_cmds++;
		else
			pow_cmds++;
	endtask

	task automatic pause_sender(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic maybe_gap(input bit allow);
		if (allow && $urandom_range(0, 3) == 0)
			pause_sender($urandom_range(1, 15));
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (expected_residues.size() != 0)
			@(posedge clk);
	endtask

	// Random command: mix of base classes and exponent widths
	task automatic rand_cmd(output logic f, output logic [62:0] b, output logic [62:0] e);
		logic [63:0] k;
		int          w;
		f = ($urandom_range(0, 9) < 3);
		case ($urandom_range(0, 5))
			0: b = {47'd0, 16'($urandom)};
			1: begin
				k = {31'd0, 1'($urandom_range(0, 1)), 32'($urandom)};
				b = 63'(k * MODULUS);
			end
			2: b = 63'(MODULUS - 64'd1 + 64'($urandom_range(0, 3)));
			3: b = 63'({32'd0, $urandom} % MODULUS);
			default: b = rand63();
		endcase
		w = $urandom_range(0, 63);
		e = rand63() & (w == 63 ? ALL_ONES : ((63'd1 << w) - 63'd1));
		if (w > 0 && $urandom_range(0, 1) == 1)
			e[w - 1] = 1'b1;
	endtask

	// Power-mode corners: zero and full exponents, zero and wrapped bases
	task automatic test_power_corners();
		issue_cmd(1'b0, 63'd0, 63'd0);
		issue_cmd(1'b0, 63'(MODULUS), 63'd0);
		issue_cmd(1'b0, ALL_ONES, 63'd0);
		issue_cmd(1'b0, ALL_ONES, 63'd1);
		issue_cmd(1'b0, 63'd0, 63'd1);
		issue_cmd(1'b0, 63'd0, ALL_ONES);
		issue_cmd(1'b0, 63'd2, ALL_ONES);
		issue_cmd(1'b0, 63'(MODULUS - 64'd1), ALL_ONES);
		issue_cmd(1'b0, 63'd2, 63'(MODULUS - 64'd1));
		issue_cmd(1'b0, 63'd3, 63'd1 << 62);
		issue_cmd(1'b0, ALL_ONES, 63'h2AAA_AAAA_AAAA_AAAA);
		issue_cmd(1'b0, 63'h2AAA_AAAA_AAAA_AAAA, 63'h5555_5555_5555_5555);
		pause_sender(3);
	endtask

	// Inverse-mode corners: zero, the modulus itself, unit, and exponent ignored
	task automatic test_inverse_corners();
		issue_cmd(1'b1, 63'd0, 63'd0);
		issue_cmd(1'b1, 63'(MODULUS), ALL_ONES);
		issue_cmd(1'b1, 63'd1, 63'd0);
		issue_cmd(1'b1, 63'd2, ALL_ONES);
		issue_cmd(1'b1, 63'(MODULUS - 64'd1), 63'd5);
		issue_cmd(1'b1, ALL_ONES, 63'd0);
		issue_cmd(1'b1, 63'(MODULUS + 64'd1), 63'h5555_5555_5555_5555);
		pause_sender(2);
	endtask

	// Random commands with idle bursts in some stretches
	task automatic test_random_mix(input int n);
		logic        f;
		logic [62:0] b;
		logic [62:0] e;
		bit          gaps;
		gaps = 1'b1;
		for (int i = 0; i < n; i++) begin
			if (i % 25 == 0)
				gaps = ($urandom_range(0, 2) != 0);
			rand_cmd(f, b, e);
			issue_cmd(f, b, e);
			maybe_gap(gaps);
		end
	endtask

	// Sender holds off until every result is back, then resumes
	task automatic test_drain_pause();
		logic        f;
		logic [62:0] b;
		logic [62:0] e;
		for (int j = 0; j < 3; j++) begin
			for (int i = 0; i < 5; i++) begin
				rand_cmd(f, b, e);
				issue_cmd(f, b, e);
			end
			drain_results();
		end
	endtask

	// Back-to-back commands to close the run
	task automatic test_back_to_back(input int n);
		logic        f;
		logic [62:0] b;
		logic [62:0] e;
		for (int i = 0; i < n; i++) begin
			rand_cmd(f, b, e);
			issue_cmd(f, b, e);
		end
		start <= 1'b0;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_power_corners();
		test_inverse_corners();
		test_random_mix(380);
		test_drain_pause();
		test_back_to_back(85);

		// wait for outstanding results, then watch for stray beats
		while (expected_residues.size() != 0)
			@(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);

		$display("ran %0d power and %0d inverse commands, %0d results compared",
			pow_cmds, inv_cmds, checked);
		$display("bases covered zero, small, wrapped multiples and full width; %0d mismatches",
			mismatches);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
